@@ design/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// shared types and constants of the seven segment serial shifter
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int BYTE_W             = 8;
    localparam int DIGITS_DEF         = 8;
    localparam int HALF_PERIOD_DEF    = 20;
    localparam int CFG_IDX_W          = 2;
    localparam int FIFO_DEPTH         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST   = 2'd1;

    typedef enum logic {
        F_COLLECT,
        F_DRAIN
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_SHIFT
    } t_back_state;

    // one digit handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] seg;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic active_high;
        logic msb_first;
    } t_cfg;

endpackage

@@ design/sss_front.sv @@
// ----------------------------------------------------------------------------
// sss_front
// collects the digit bytes of a frame, then drains them newest first
// ----------------------------------------------------------------------------
module sss_front #(
    parameter int DIGITS = sss_pkg::DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [sss_pkg::BYTE_W-1:0]   i_segment_byte,
    input  logic                         i_end_of_frame,
    output logic                         o_q_push,
    output sss_pkg::t_entry              o_q_data,
    input  logic                         i_q_full
);
    import sss_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam logic [CNT_W-1:0] LIM = CNT_W'(DIGITS);

    logic [BYTE_W-1:0] r_store [DIGITS];
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_rd, n_rd;
    t_front_state      r_state, n_state;

    logic             accept;
    logic             room;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;

    assign full   = (r_state == F_DRAIN);
    assign accept = push && !full;
    assign room   = (r_cnt < LIM);

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_store[r_cnt[IDX_W-1:0]] <= i_segment_byte;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        o_q_push = 1'b0;
        o_q_data.seg  = r_store[r_rd];
        o_q_data.last = (r_rd == '0);
        cnt_inc  = room ? (r_cnt + CNT_W'(1)) : r_cnt;
        cnt_dec  = cnt_inc - CNT_W'(1);
        case (r_state)
            F_COLLECT: begin
                if (accept) begin
                    n_cnt = cnt_inc;
                    if (i_end_of_frame) begin
                        n_rd    = cnt_dec[IDX_W-1:0];
                        n_state = F_DRAIN;
                    end
                end
            end
            F_DRAIN: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    if (r_rd == '0) begin
                        n_cnt   = '0;
                        n_state = F_COLLECT;
                    end else begin
                        n_rd = r_rd - IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = F_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_COLLECT;
            r_cnt   <= '0;
            r_rd    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
        end
    end

endmodule

@@ design/sss_fifo.sv @@
// ----------------------------------------------------------------------------
// sss_fifo
// short queue of digit entries between front and back
// ----------------------------------------------------------------------------
module sss_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sss_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output sss_pkg::t_entry o_data,
    output logic            o_empty
);
    import sss_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/sss_back.sv @@
// ----------------------------------------------------------------------------
// sss_back
// shifts each digit out one bit at a time, paced by the shift clock timer
// ----------------------------------------------------------------------------
module sss_back #(
    parameter int HALF_PERIOD_CYCLES = sss_pkg::HALF_PERIOD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sss_pkg::t_cfg   i_cfg,
    input  sss_pkg::t_entry i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output logic            o_data_bit,
    output logic            o_latch_after
);
    import sss_pkg::*;

    localparam int TMR_W = (2 * HALF_PERIOD_CYCLES > 1) ? $clog2(2 * HALF_PERIOD_CYCLES) : 1;
    localparam logic [TMR_W-1:0] TMR_LOAD = TMR_W'(2 * HALF_PERIOD_CYCLES - 1);
    localparam int BIT_W = $clog2(BYTE_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BYTE_W - 1);

    t_back_state       r_state, n_state;
    logic [BYTE_W-1:0] r_sh, n_sh;
    logic              r_last, n_last;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [TMR_W-1:0]  r_tmr, n_tmr;
    logic              r_out_valid, n_out_valid;
    logic              r_out_data, n_out_data;
    logic              r_out_latch, n_out_latch;

    logic              slot_free;
    logic [BYTE_W-1:0] polar;
    logic [BYTE_W-1:0] ordered;

    assign empty         = !r_out_valid;
    assign o_data_bit    = r_out_data;
    assign o_latch_after = r_out_latch;
    assign slot_free     = !r_out_valid || pop;

    // always send from the top bit: lsb first is a reversed byte
    always_comb begin
        polar = i_cfg.active_high ? i_q_data.seg : ~i_q_data.seg;
        for (int i = 0; i < BYTE_W; i++) begin
            ordered[i] = polar[BYTE_W-1-i];
        end
        if (i_cfg.msb_first) begin
            ordered = polar;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sh        = r_sh;
        n_last      = r_last;
        n_bit       = r_bit;
        n_tmr       = r_tmr;
        n_out_data  = r_out_data;
        n_out_latch = r_out_latch;
        n_out_valid = pop ? 1'b0 : r_out_valid;
        o_q_pop     = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_sh    = ordered;
                    n_last  = i_q_data.last;
                    n_bit   = '0;
                    n_tmr   = TMR_LOAD;
                    n_state = B_SHIFT;
                end
            end
            B_SHIFT: begin
                if (r_tmr != '0) begin
                    n_tmr = r_tmr - TMR_W'(1);
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sh[BYTE_W-1];
                    n_out_latch = r_last && (r_bit == BIT_LAST);
                    n_sh        = {r_sh[BYTE_W-2:0], 1'b0};
                    n_bit       = r_bit + BIT_W'(1);
                    if (r_bit == BIT_LAST) begin
                        n_state = B_IDLE;
                    end else begin
                        n_tmr = TMR_LOAD;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sh        <= n_sh;
        r_last      <= n_last;
        r_out_data  <= n_out_data;
        r_out_latch <= n_out_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_bit       <= '0;
            r_tmr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_tmr       <= n_tmr;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/seven_segment_serial_shifter_top.sv @@
// ----------------------------------------------------------------------------
// seven_segment_serial_shifter_top
// serializer for a chain of 595-style shift registers driving digits
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         push / full               i_segment_byte, i_end_of_frame
// result    out        empty / pop               o_data_bit, o_latch_after
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a byte without end mark is taken in the same cycle as its push
// after an end mark, input holds full until the front has drained all stored
// bytes into the queue; a full queue holds the drain
// each byte is first loaded from the queue, then each serial bit is paced by
// the back timer; a stalled pop holds the shifter
// synchronous active-low reset; config registers reset to 1
// ----------------------------------------------------------------------------
module seven_segment_serial_shifter_top #(
    parameter int DIGITS             = sss_pkg::DIGITS_DEF,
    parameter int HALF_PERIOD_CYCLES = sss_pkg::HALF_PERIOD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sss_pkg::BYTE_W-1:0]    i_segment_byte,
    input  logic                          i_end_of_frame,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_data_bit,
    output logic                          o_latch_after,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);
    import sss_pkg::*;

    t_cfg   r_cfg;
    t_entry q_in, q_out;
    logic   q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high <= 1'b1;
            r_cfg.msb_first   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACTIVE_HIGH: r_cfg.active_high <= i_cfg_data;
                CFG_MSB_FIRST:   r_cfg.msb_first   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    sss_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_segment_byte (i_segment_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_q_push       (q_push),
        .o_q_data       (q_in),
        .i_q_full       (q_full)
    );

    sss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    sss_back #(
        .HALF_PERIOD_CYCLES (HALF_PERIOD_CYCLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_data      (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_data_bit    (o_data_bit),
        .o_latch_after (o_latch_after)
    );

endmodule
